FILE: sv/bga_pkg.sv
// Package for the battery gauge averager: payload structs, register indexes,
// status codes and shared constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bga_pkg;

    typedef struct packed {
        logic [2:0]  battery_status;
        logic [30:0] voltage_sample;
        logic [30:0] current_sample;
        logic [30:0] power_sample;
        logic [30:0] level_sample;
    } t_in_item;

    typedef struct packed {
        logic [31:0] avg_power;
        logic [31:0] present_power;
        logic [31:0] avg_current;
        logic [31:0] present_current;
        logic [31:0] seconds_remaining;
        logic [30:0] full_level;
    } t_out_item;

    // Work item handed from the front to the back: updated averages and
    // the values the back needs for its divisions.
    typedef struct packed {
        logic [30:0] v;
        logic [30:0] i;
        logic [30:0] p;
        logic [30:0] pavg;
        logic [30:0] vavg;
        logic [30:0] iavg;
        logic [31:0] diff;
        logic        applies;
        logic [30:0] full;
    } t_work;

    typedef struct packed {
        logic energy_mode;
        logic has_current;
        logic has_power;
    } t_cfg;

    localparam logic [1:0] REG_ENERGY_MODE  = 2'd0;
    localparam logic [1:0] REG_HAS_CURRENT  = 2'd1;
    localparam logic [1:0] REG_HAS_POWER    = 2'd2;
    localparam logic [1:0] REG_INITIAL_FULL = 2'd3;

    localparam logic [2:0] ST_CHARGING    = 3'd1;
    localparam logic [2:0] ST_DISCHARGING = 3'd2;

    localparam int unsigned DIV_W = 52;

    // x / 1000 for any 31-bit x: (x * RECIP_1000) >> 38
    localparam logic [28:0] RECIP_1000 = 29'd274877907;

    typedef enum logic [2:0] {
        B_IDLE, B_DIV_PAVG, B_DIV_P, B_DIV_SECS, B_OUT
    } t_back_state;

endpackage
`default_nettype wire

FILE: sv/bga_divider.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 32
// bits. Depends on bga_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bga_divider (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire [bga_pkg::DIV_W-1:0] i_num,
    input  wire [30:0]            i_den,
    output logic                  o_done,
    output logic [31:0]           o_quot
);
    import bga_pkg::*;

    logic [DIV_W-1:0] r_num, n_num;
    logic [DIV_W-1:0] r_q, n_q;
    logic [30:0]      r_rem, n_rem;
    logic [30:0]      r_den;
    logic [5:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [31:0]      w_trial;

    // Shift one numerator bit into the remainder and try a subtract
    always_comb begin
        w_trial = {r_rem, r_num[DIV_W-1]};
        n_num   = {r_num[DIV_W-2:0], 1'b0};
        n_rem   = w_trial[30:0];
        n_q     = {r_q[DIV_W-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = 31'(w_trial - {1'b0, r_den});
            n_q[0] = 1'b1;
        end
        n_cnt  = r_cnt - 6'd1;
        n_busy = r_busy;
        n_done = 1'b0;
        if (r_busy && r_cnt == 6'd1) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= 6'(DIV_W);
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_q   <= n_q;
            r_cnt <= n_cnt;
        end
    end

    assign o_done = r_done;
    assign o_quot = (|r_q[DIV_W-1:32]) ? 32'hFFFF_FFFF : r_q[31:0];

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
endmodule
`default_nettype wire

FILE: sv/bga_front.sv
// Front: accepts samples, updates averages and full level, forms the work
// item. Depends on bga_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bga_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_take,
    input  bga_pkg::t_in_item  i_item,
    input  wire [30:0]         i_init_full,
    output bga_pkg::t_work     o_work
);
    import bga_pkg::*;

    logic [30:0] r_pavg, r_vavg, r_iavg, r_full;
    logic        r_first;
    logic [30:0] w_full, w_vbase, w_pavg, w_vavg, w_iavg, w_base_full;

    function automatic logic [30:0] ema(input logic [30:0] avg, input logic [30:0] now);
        logic signed [32:0] d;
        logic signed [32:0] q;
        logic signed [32:0] s;
        d = $signed({2'b0, now}) - $signed({2'b0, avg});
        q = (d < 0) ? -((-d) >>> 3) : (d >>> 3);
        s = $signed({2'b0, avg}) + q;
        return s[30:0];
    endfunction

    // Seed the voltage average and full-level base on the first sample, then update
    always_comb begin
        w_base_full = r_first ? i_init_full : r_full;
        w_vbase     = r_first ? i_item.voltage_sample : r_vavg;
        w_full      = (i_item.level_sample > w_base_full) ? i_item.level_sample : w_base_full;
        w_pavg      = ema(r_pavg, i_item.power_sample);
        w_vavg      = ema(w_vbase, i_item.voltage_sample);
        w_iavg      = ema(r_iavg, i_item.current_sample);
        o_work.v    = i_item.voltage_sample;
        o_work.i    = i_item.current_sample;
        o_work.p    = i_item.power_sample;
        o_work.pavg = w_pavg;
        o_work.vavg = w_vavg;
        o_work.iavg = w_iavg;
        o_work.full = w_full;
        o_work.applies = 1'b1;
        o_work.diff = '0;
        priority if (i_item.battery_status == ST_CHARGING)
            o_work.diff = 32'(w_full - i_item.level_sample);
        else if (i_item.battery_status == ST_DISCHARGING)
            o_work.diff = {1'b0, i_item.level_sample};
        else
            o_work.applies = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pavg  <= '0;
            r_vavg  <= '0;
            r_iavg  <= '0;
            r_full  <= '0;
            r_first <= 1'b1;
        end else if (i_take) begin
            r_pavg  <= w_pavg;
            r_vavg  <= w_vavg;
            r_iavg  <= w_iavg;
            r_full  <= w_full;
            r_first <= 1'b0;
        end
    end

    a_first_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |=> !r_first) else $error("first flag survived a sample");
endmodule
`default_nettype wire

FILE: sv/bga_back.sv
// Back: three divisions on the shared divider, power products, result
// register. Depends on bga_pkg and bga_divider.
`timescale 1ns / 1ps
`default_nettype none
module bga_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  bga_pkg::t_work     i_work,
    input  bga_pkg::t_cfg      i_cfg,
    output logic               o_take,
    output logic               o_out_valid,
    output bga_pkg::t_out_item o_out,
    input  wire                i_out_take
);
    import bga_pkg::*;

    t_back_state r_st, n_st;
    t_work       r_w;
    logic [31:0] r_cur_avg, r_cur_now, r_secs;
    logic [31:0] r_pw_avg, r_pw_now;
    logic [21:0] r_vk_avg, r_ik_avg, r_vk_now, r_ik_now;
    logic [43:0] r_prod_a, r_prod_b;
    logic        r_pend;
    logic        w_start;
    logic [DIV_W-1:0] w_num;
    logic [30:0] w_den;
    logic        w_done;
    logic [31:0] w_quot;
    logic [30:0] w_rate;

    // Divide by 1000 through a reciprocal multiply
    function automatic logic [21:0] div1000(input logic [30:0] x);
        logic [59:0] m;
        m = 60'(x) * 60'(RECIP_1000);
        return m[59:38];
    endfunction

    bga_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_done), .o_quot(w_quot)
    );

    assign w_rate = i_cfg.energy_mode ? r_w.pavg : r_w.iavg;

    // Sequence the divisions
    always_comb begin
        n_st    = r_st;
        w_start = 1'b0;
        w_num   = '0;
        w_den   = '0;
        o_take  = 1'b0;
        unique case (r_st)
            B_IDLE: begin
                if (i_valid && !o_out_valid) begin
                    o_take = 1'b1;
                    n_st   = B_DIV_PAVG;
                end
            end
            B_DIV_PAVG: begin
                if (!r_pend) begin
                    w_start = 1'b1;
                    w_num   = DIV_W'(r_w.pavg) * DIV_W'(1000000);
                    w_den   = r_w.vavg;
                end else if (w_done) begin
                    n_st = B_DIV_P;
                end
            end
            B_DIV_P: begin
                if (!r_pend) begin
                    w_start = 1'b1;
                    w_num   = DIV_W'(r_w.p) * DIV_W'(1000000);
                    w_den   = r_w.v;
                end else if (w_done) begin
                    n_st = B_DIV_SECS;
                end
            end
            B_DIV_SECS: begin
                if (!r_pend) begin
                    w_start = 1'b1;
                    w_num   = DIV_W'(r_w.diff) * DIV_W'(3600);
                    w_den   = w_rate;
                end else if (w_done) begin
                    n_st = B_OUT;
                end
            end
            B_OUT: n_st = B_IDLE;
            default: n_st = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= B_IDLE;
            r_pend      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_start) r_pend <= 1'b1;
            else if (w_done) r_pend <= 1'b0;
            if (r_st == B_OUT) o_out_valid <= 1'b1;
            else if (i_out_take) o_out_valid <= 1'b0;
        end
        if (o_take)
            r_w <= i_work;
        // Scale voltage and current down, then multiply, then saturate
        if (r_st == B_DIV_PAVG && !r_pend) begin
            r_vk_avg <= div1000(r_w.vavg);
            r_ik_avg <= div1000(r_w.iavg);
            r_vk_now <= div1000(r_w.v);
            r_ik_now <= div1000(r_w.i);
        end
        if (r_st == B_DIV_PAVG && r_pend) begin
            r_prod_a <= 44'(r_vk_avg) * 44'(r_ik_avg);
            r_prod_b <= 44'(r_vk_now) * 44'(r_ik_now);
        end
        if (r_st == B_DIV_PAVG && w_done)
            r_cur_avg <= (r_w.vavg == '0) ? '0 : w_quot;
        if (r_st == B_DIV_P && w_done)
            r_cur_now <= (r_w.v == '0) ? '0 : w_quot;
        if (r_st == B_DIV_SECS && w_done)
            r_secs <= (w_rate == '0 || !r_w.applies) ? '0 : w_quot;
        if (r_st == B_DIV_P) begin
            r_pw_avg <= (|r_prod_a[43:32]) ? 32'hFFFF_FFFF : r_prod_a[31:0];
            r_pw_now <= (|r_prod_b[43:32]) ? 32'hFFFF_FFFF : r_prod_b[31:0];
        end
        if (r_st == B_OUT) begin
            o_out.full_level        <= r_w.full;
            o_out.seconds_remaining <= r_secs;
            o_out.avg_power     <= i_cfg.has_power ? {1'b0, r_w.pavg} :
                                   i_cfg.has_current ? r_pw_avg : '0;
            o_out.present_power <= i_cfg.has_power ? {1'b0, r_w.p} :
                                   i_cfg.has_current ? r_pw_now : '0;
            o_out.avg_current   <= i_cfg.has_current ? {1'b0, r_w.iavg} :
                                   i_cfg.has_power ? r_cur_avg : '0;
            o_out.present_current <= i_cfg.has_current ? {1'b0, r_w.i} :
                                   i_cfg.has_power ? r_cur_now : '0;
        end
    end

    a_take_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> !o_out_valid) else $error("took work with result pending");
    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !r_pend) else $error("divider restarted while pending");
endmodule
`default_nettype wire

FILE: sv/battery_gauge_averager_core.sv
// Battery gauge averager top level: configuration registers, front, a
// one-entry work queue and back. Depends on bga_pkg, bga_front, bga_back.
//
// Usage: raise push with a sample on i_in while full is low. Each sample
// yields one result on o_out, shown while empty is low and taken with pop.
// Registers are written on the cfg channel (index 0 energy mode, 1 current
// reading, 2 power reading, 3 initial full level) only while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
// From the accepting edge until empty falls, a sample passes the work queue
// register, three divisions on the one shared 52-step restoring divider,
// and the result register. The back handles one sample at a time and
// takes the next work item the cycle after the result is popped, while
// one further sample can wait in the work queue.
// Reset clears all averages and configuration and re-arms the first-sample
// flag. If the receiver does not pop, the result holds and the back stalls;
// the queue fills and full rises.
`timescale 1ns / 1ps
`default_nettype none
module battery_gauge_averager_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  bga_pkg::t_in_item   i_in,
    output logic                empty,
    input  wire                 pop,
    output bga_pkg::t_out_item  o_out,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [1:0]           i_cfg_index,
    input  wire [30:0]          i_cfg_data
);
    import bga_pkg::*;

    t_cfg        r_cfg;
    logic [30:0] r_init_full;
    t_work       w_work, r_q;
    logic        r_q_valid;
    logic        w_take_in, w_back_take, w_out_valid;

    assign o_cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_init_full <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENERGY_MODE:  r_cfg.energy_mode <= i_cfg_data[0];
                REG_HAS_CURRENT:  r_cfg.has_current <= i_cfg_data[0];
                REG_HAS_POWER:    r_cfg.has_power   <= i_cfg_data[0];
                REG_INITIAL_FULL: r_init_full       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign full      = r_q_valid;
    assign w_take_in = push && !r_q_valid;

    bga_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take_in), .i_item(i_in),
        .i_init_full(r_init_full), .o_work(w_work)
    );

    // Hold one work item between front and back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_q_valid <= 1'b0;
        else if (w_take_in) r_q_valid <= 1'b1;
        else if (w_back_take) r_q_valid <= 1'b0;
        if (w_take_in) r_q <= w_work;
    end

    bga_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_q_valid), .i_work(r_q),
        .i_cfg(r_cfg), .o_take(w_back_take), .o_out_valid(w_out_valid),
        .o_out(o_out), .i_out_take(pop)
    );

    assign empty = !w_out_valid;

    a_take_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_take |-> r_q_valid) else $error("back took from empty queue");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take_in |-> !w_back_take) else $error("queue written and read at once");
endmodule
`default_nettype wire
